/* rtl/hs_pkg.sv */
// ----------------------------------------------------------------------------
// hs_pkg: shared types and microcode for the heap sorter
// Holds the control word format, the status flags that the datapath reports
// back to the sequencer, and the read-only microprogram itself.
// ----------------------------------------------------------------------------
package hs_pkg;

    localparam int DATA_W = 32;
    localparam int PC_W   = 5;

    // Datapath operations, one per microcode step.
    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_INIT,
        OP_B_DEC,
        OP_LD_RV,
        OP_SIFT_RD,
        OP_SIFT_CMP,
        OP_WR_RV,
        OP_X_START,
        OP_X_SWAP,
        OP_E_INIT,
        OP_E_RD,
        OP_E_OUT,
        OP_FINISH
    } op_t;

    // Jump conditions; the jump is taken when the condition holds.
    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_NOT_LAST_IN,
        C_SMALL,
        C_LEAF,
        C_DESCEND,
        C_I_NONZERO,
        C_N_GT1,
        C_OUT_BUSY,
        C_MORE
    } cond_t;

    typedef struct packed {
        op_t              op;
        cond_t            cond;
        logic [PC_W-1:0]  target;
    } ctrl_t;

    typedef struct packed {
        logic last_in;
        logic below_two;
        logic leaf;
        logic descend;
        logic i_nonzero;
        logic n_gt1;
        logic out_busy;
        logic more;
    } status_t;

    // Program entry points used as jump targets.
    localparam logic [PC_W-1:0] ST_LOAD    = 5'd0;
    localparam logic [PC_W-1:0] ST_B_DEC   = 5'd2;
    localparam logic [PC_W-1:0] ST_B_SRD   = 5'd4;
    localparam logic [PC_W-1:0] ST_B_WR    = 5'd6;
    localparam logic [PC_W-1:0] ST_X_START = 5'd7;
    localparam logic [PC_W-1:0] ST_X_SRD   = 5'd9;
    localparam logic [PC_W-1:0] ST_X_WR    = 5'd11;
    localparam logic [PC_W-1:0] ST_E_INIT  = 5'd12;
    localparam logic [PC_W-1:0] ST_E_RD    = 5'd13;
    localparam logic [PC_W-1:0] ST_E_WAIT  = 5'd15;

    // Microprogram: load, build the heap, extract the maximum repeatedly,
    // then stream the sorted store out.
    function automatic ctrl_t ucode(input logic [PC_W-1:0] pc);
        ctrl_t w;
        w = '{op: OP_NOP, cond: C_ALWAYS, target: ST_LOAD};
        case (pc)
            5'd0:  w = '{op: OP_LOAD,     cond: C_NOT_LAST_IN, target: ST_LOAD};
            5'd1:  w = '{op: OP_INIT,     cond: C_SMALL,       target: ST_E_INIT};
            5'd2:  w = '{op: OP_B_DEC,    cond: C_NEVER,       target: ST_LOAD};
            5'd3:  w = '{op: OP_LD_RV,    cond: C_NEVER,       target: ST_LOAD};
            5'd4:  w = '{op: OP_SIFT_RD,  cond: C_LEAF,        target: ST_B_WR};
            5'd5:  w = '{op: OP_SIFT_CMP, cond: C_DESCEND,     target: ST_B_SRD};
            5'd6:  w = '{op: OP_WR_RV,    cond: C_I_NONZERO,   target: ST_B_DEC};
            5'd7:  w = '{op: OP_X_START,  cond: C_NEVER,       target: ST_LOAD};
            5'd8:  w = '{op: OP_X_SWAP,   cond: C_NEVER,       target: ST_LOAD};
            5'd9:  w = '{op: OP_SIFT_RD,  cond: C_LEAF,        target: ST_X_WR};
            5'd10: w = '{op: OP_SIFT_CMP, cond: C_DESCEND,     target: ST_X_SRD};
            5'd11: w = '{op: OP_WR_RV,    cond: C_N_GT1,       target: ST_X_START};
            5'd12: w = '{op: OP_E_INIT,   cond: C_NEVER,       target: ST_LOAD};
            5'd13: w = '{op: OP_E_RD,     cond: C_NEVER,       target: ST_LOAD};
            5'd14: w = '{op: OP_E_OUT,    cond: C_NEVER,       target: ST_LOAD};
            5'd15: w = '{op: OP_NOP,      cond: C_OUT_BUSY,    target: ST_E_WAIT};
            5'd16: w = '{op: OP_NOP,      cond: C_MORE,        target: ST_E_RD};
            5'd17: w = '{op: OP_FINISH,   cond: C_ALWAYS,      target: ST_LOAD};
            default: w = '{op: OP_NOP,    cond: C_ALWAYS,      target: ST_LOAD};
        endcase
        return w;
    endfunction

endpackage

/* rtl/hs_items_if.sv */
// ----------------------------------------------------------------------------
// hs_items_if: input channel of the heap sorter
// Carries one list element per transfer, with a flag on the final element.
// ----------------------------------------------------------------------------
interface hs_items_if;

    logic                              valid;
    logic                              ready;
    logic signed [hs_pkg::DATA_W-1:0]  value;
    logic                              last;

    modport source (output valid, output value, output last, input ready);
    modport sink   (input valid, input value, input last, output ready);

endinterface

/* rtl/hs_results_if.sv */
// ----------------------------------------------------------------------------
// hs_results_if: output channel of the heap sorter
// Carries one sorted element per transfer with its end and overflow flags.
// ----------------------------------------------------------------------------
interface hs_results_if;

    logic                              valid;
    logic                              ready;
    logic signed [hs_pkg::DATA_W-1:0]  sorted_value;
    logic                              last_out;
    logic                              overflow;

    modport source (output valid, output sorted_value, output last_out,
                    output overflow, input ready);
    modport sink   (input valid, input sorted_value, input last_out,
                    input overflow, output ready);

endinterface

/* rtl/heap_sorter.sv */
// ----------------------------------------------------------------------------
// heap_sorter: heapsort of a list of signed 32-bit values
// The items channel takes one element per transfer; the element flagged last
// closes the list. Up to MAX_ITEMS elements are kept, later ones are dropped
// and every result of that list then carries the overflow flag.
// After the closing transfer the block builds a max-heap in its store, swaps
// the root to the end of the shrinking heap and sifts down, then sends the
// list in ascending order on the results channel, last_out on the final one.
// Loading takes a transfer whenever items.valid is high. Each sift-down level
// is a two-port read of both children, then compare and write; a sift has
// setup steps that fetch the sifted value and ends with a child read at the
// bottom and the write of that value. Each result takes a read, an output
// step and the sequencer's checks, plus the time the receiver holds ready low;
// while results.ready is low the output register holds its transfer and the
// sequencer waits. items.ready is high only during loading. Reset clears the
// element count, the drop flag and the output valid, and the block starts in
// loading; the store needs no clearing pass.
// ----------------------------------------------------------------------------
module heap_sorter #(
    parameter int MAX_ITEMS = 64
) (
    input  logic          clk,
    input  logic          rst_n,
    hs_items_if.sink      items,
    hs_results_if.source  results
);

    hs_pkg::ctrl_t   ctrl;
    hs_pkg::status_t status;

    // Microprogram sequencer.
    hs_sequencer u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .ctrl   (ctrl)
    );

    // Store, indices and output register.
    hs_datapath #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (ctrl),
        .status  (status),
        .items   (items),
        .results (results)
    );

    // No result is pending while elements are being loaded.
    a_load_no_result : assert property (@(posedge clk) disable iff (!rst_n)
        items.ready |-> !results.valid)
        else $error("result pending during loading");

    // A compare step is always preceded by the read of both children.
    a_cmp_after_read : assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.op == hs_pkg::OP_SIFT_CMP) |-> ($past(ctrl.op) == hs_pkg::OP_SIFT_RD))
        else $error("sift compare without child read");

    // A new result appears only from the output step.
    a_result_source : assert property (@(posedge clk) disable iff (!rst_n)
        $rose(results.valid) |-> ($past(ctrl.op) == hs_pkg::OP_E_OUT))
        else $error("result raised outside the output step");

endmodule

/* rtl/hs_sequencer.sv */
// ----------------------------------------------------------------------------
// hs_sequencer: microprogram sequencer
// Steps through the read-only program and takes conditional jumps on the
// status flags reported by the datapath.
// ----------------------------------------------------------------------------
module hs_sequencer (
    input  logic             clk,
    input  logic             rst_n,
    input  hs_pkg::status_t  status,
    output hs_pkg::ctrl_t    ctrl
);

    logic [hs_pkg::PC_W-1:0] pc_reg;
    logic [hs_pkg::PC_W-1:0] pc_next;
    logic                    take;

    // Fetch the control word of the current step.
    assign ctrl = hs_pkg::ucode(pc_reg);

    // Evaluate the jump condition.
    always_comb
    begin
        case (ctrl.cond)
            hs_pkg::C_NEVER:       take = 1'b0;
            hs_pkg::C_ALWAYS:      take = 1'b1;
            hs_pkg::C_NOT_LAST_IN: take = !status.last_in;
            hs_pkg::C_SMALL:       take = status.below_two;
            hs_pkg::C_LEAF:        take = status.leaf;
            hs_pkg::C_DESCEND:     take = status.descend;
            hs_pkg::C_I_NONZERO:   take = status.i_nonzero;
            hs_pkg::C_N_GT1:       take = status.n_gt1;
            hs_pkg::C_OUT_BUSY:    take = status.out_busy;
            hs_pkg::C_MORE:        take = status.more;
            default:               take = 1'b0;
        endcase
        pc_next = take ? ctrl.target : pc_reg + hs_pkg::PC_W'(1);
    end

    // Step counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= hs_pkg::ST_LOAD;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule

/* rtl/hs_datapath.sv */
// ----------------------------------------------------------------------------
// hs_datapath: storage and arithmetic of the heap sorter
// Holds the element store with one write and two registered read ports, the
// heap indices, the sifted value and the output register.
// ----------------------------------------------------------------------------
module hs_datapath #(
    parameter int MAX_ITEMS = 64
) (
    input  logic             clk,
    input  logic             rst_n,
    input  hs_pkg::ctrl_t    ctrl,
    output hs_pkg::status_t  status,
    hs_items_if.sink         items,
    hs_results_if.source     results
);

    localparam int AW = $clog2(MAX_ITEMS);
    localparam int CW = $clog2(MAX_ITEMS + 1);
    localparam int LW = AW + 2;
    localparam int DW = hs_pkg::DATA_W;

    logic signed [DW-1:0] mem [MAX_ITEMS];

    logic [CW-1:0]        count_reg, count_next;
    logic                 dropped_reg, dropped_next;
    logic [CW-1:0]        n_reg, n_next;
    logic [CW-1:0]        i_reg, i_next;
    logic [AW-1:0]        r_reg, r_next;
    logic signed [DW-1:0] rv_reg, rv_next;
    logic signed [DW-1:0] rd_a_reg, rd_b_reg;
    logic                 out_valid_reg, out_valid_next;
    logic signed [DW-1:0] sorted_reg, sorted_next;
    logic                 last_reg, last_next;
    logic                 ovf_reg, ovf_next;

    logic                 we;
    logic [AW-1:0]        waddr;
    logic signed [DW-1:0] wdata;
    logic [AW-1:0]        ra_addr, rb_addr;

    logic                 in_xfer, out_xfer;
    logic [LW-1:0]        left, right, n_ext;
    logic                 right_big;
    logic signed [DW-1:0] big_val;
    logic [AW-1:0]        big_idx;
    logic [CW-1:0]        i_dec, i_inc, n_dec;

    // Handshake and channel outputs.
    assign items.ready          = (ctrl.op == hs_pkg::OP_LOAD);
    assign in_xfer              = items.valid && items.ready;
    assign out_xfer             = results.valid && results.ready;
    assign results.valid        = out_valid_reg;
    assign results.sorted_value = sorted_reg;
    assign results.last_out     = last_reg;
    assign results.overflow     = ovf_reg;

    // Child indices and the larger-child selection.
    assign left      = {1'b0, r_reg, 1'b1};
    assign right     = left + LW'(1);
    assign n_ext     = LW'(n_reg);
    assign right_big = (right < n_ext) && (rd_b_reg > rd_a_reg);
    assign big_val   = right_big ? rd_b_reg : rd_a_reg;
    assign big_idx   = right_big ? right[AW-1:0] : left[AW-1:0];
    assign i_dec     = i_reg - CW'(1);
    assign i_inc     = i_reg + CW'(1);
    assign n_dec     = n_reg - CW'(1);

    // Status flags for the sequencer.
    always_comb
    begin
        status.last_in   = in_xfer && items.last;
        status.below_two = count_reg < CW'(2);
        status.leaf      = left >= n_ext;
        status.descend   = rv_reg < big_val;
        status.i_nonzero = i_reg != '0;
        status.n_gt1     = n_reg > CW'(1);
        status.out_busy  = out_valid_reg && !results.ready;
        status.more      = i_reg < count_reg;
    end

    // Operation decode.
    always_comb
    begin
        count_next     = count_reg;
        dropped_next   = dropped_reg;
        n_next         = n_reg;
        i_next         = i_reg;
        r_next         = r_reg;
        rv_next        = rv_reg;
        out_valid_next = out_xfer ? 1'b0 : out_valid_reg;
        sorted_next    = sorted_reg;
        last_next      = last_reg;
        ovf_next       = ovf_reg;
        we             = 1'b0;
        waddr          = r_reg;
        wdata          = rv_reg;
        ra_addr        = '0;
        rb_addr        = '0;
        case (ctrl.op)
            hs_pkg::OP_LOAD:
            begin
                if (in_xfer)
                begin
                    if (count_reg < CW'(MAX_ITEMS))
                    begin
                        we         = 1'b1;
                        waddr      = count_reg[AW-1:0];
                        wdata      = items.value;
                        count_next = count_reg + CW'(1);
                    end
                    else
                    begin
                        dropped_next = 1'b1;
                    end
                end
            end
            hs_pkg::OP_INIT:
            begin
                n_next = count_reg;
                i_next = count_reg >> 1;
            end
            hs_pkg::OP_B_DEC:
            begin
                i_next  = i_dec;
                r_next  = i_dec[AW-1:0];
                ra_addr = i_dec[AW-1:0];
            end
            hs_pkg::OP_LD_RV:
            begin
                rv_next = rd_a_reg;
            end
            hs_pkg::OP_SIFT_RD:
            begin
                ra_addr = left[AW-1:0];
                rb_addr = right[AW-1:0];
            end
            hs_pkg::OP_SIFT_CMP:
            begin
                // Move the larger child up into the hole and follow it down.
                if (status.descend)
                begin
                    we     = 1'b1;
                    waddr  = r_reg;
                    wdata  = big_val;
                    r_next = big_idx;
                end
            end
            hs_pkg::OP_WR_RV:
            begin
                we    = 1'b1;
                waddr = r_reg;
                wdata = rv_reg;
            end
            hs_pkg::OP_X_START:
            begin
                n_next  = n_dec;
                ra_addr = '0;
                rb_addr = n_dec[AW-1:0];
            end
            hs_pkg::OP_X_SWAP:
            begin
                // The root goes to the end; the old end value is sifted from the root.
                we      = 1'b1;
                waddr   = n_reg[AW-1:0];
                wdata   = rd_a_reg;
                rv_next = rd_b_reg;
                r_next  = '0;
            end
            hs_pkg::OP_E_INIT:
            begin
                i_next = '0;
            end
            hs_pkg::OP_E_RD:
            begin
                ra_addr = i_reg[AW-1:0];
            end
            hs_pkg::OP_E_OUT:
            begin
                out_valid_next = 1'b1;
                sorted_next    = rd_a_reg;
                last_next      = (i_inc == count_reg);
                ovf_next       = dropped_reg;
                i_next         = i_inc;
            end
            hs_pkg::OP_FINISH:
            begin
                count_next   = '0;
                dropped_next = 1'b0;
            end
            default:
            begin
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            dropped_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            dropped_reg   <= dropped_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Index, value and output payload registers.
    always_ff @(posedge clk)
    begin
        n_reg      <= n_next;
        i_reg      <= i_next;
        r_reg      <= r_next;
        rv_reg     <= rv_next;
        sorted_reg <= sorted_next;
        last_reg   <= last_next;
        ovf_reg    <= ovf_next;
    end

    // Element store: one write port, two registered read ports.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rd_a_reg <= mem[ra_addr];
        rd_b_reg <= mem[rb_addr];
    end

endmodule
